>>> design/ffa_pkg.sv
// ----------------------------------------------------------------------------
// ffa_pkg
// shared types, sizes and codes of the first-fit heap allocator
// ----------------------------------------------------------------------------
`default_nettype none

package ffa_pkg;

  localparam int MAX_BLOCKS     = 256;
  localparam int HEADER_BYTES   = 12;
  localparam int SIZE_W         = 24;
  localparam int CNT_W          = $clog2(MAX_BLOCKS + 1);
  localparam int OFF_W          = 25;
  localparam int WANT_W         = 26;
  localparam int HEAP_LIMIT     = 16777216;
  localparam int RST_HEAP_BYTES = 1048576;

  localparam logic REQ_ALLOC = 1'b0;
  localparam logic REQ_FREE  = 1'b1;

  localparam logic REG_BASE  = 1'b0;
  localparam logic REG_BYTES = 1'b1;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_FAIL    = 2'd1,
    ST_UNKNOWN = 2'd2
  } status_t;

  typedef struct packed {
    logic              vld;
    logic              used;
    logic [SIZE_W-1:0] size;
  } ent_t;

  // payload size of the single block that fills a fresh heap
  function automatic logic [SIZE_W-1:0] first_size(input logic [24:0] hb);
    logic [24:0] tot;
    tot = (hb > 25'(HEAP_LIMIT)) ? 25'(HEAP_LIMIT) : hb;
    return (tot > 25'(HEADER_BYTES)) ? SIZE_W'(tot - 25'(HEADER_BYTES)) : '0;
  endfunction

endpackage

`default_nettype wire

>>> design/ffa_cell.sv
// ----------------------------------------------------------------------------
// ffa_cell
// one slot of the block queue; moves its entry left when the left slot is empty
// ----------------------------------------------------------------------------
`default_nettype none

module ffa_cell (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          clear,
  input  wire ffa_pkg::ent_t init,
  input  wire logic          go,
  input  wire ffa_pkg::ent_t right,
  output ffa_pkg::ent_t      ent
);
  import ffa_pkg::*;

  ent_t ent_r;
  ent_t ent_nxt;

  always_comb begin
    ent_nxt = ent_r;
    if (!ent_r.vld && right.vld) begin
      ent_nxt = right;
    end else if (ent_r.vld && go) begin
      ent_nxt.vld = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || clear) begin
      ent_r <= init;
    end else begin
      ent_r <= ent_nxt;
    end
  end

  assign ent = ent_r;

endmodule

`default_nettype wire

>>> design/ffa_chain.sv
// ----------------------------------------------------------------------------
// ffa_chain
// row of queue cells holding the block table in address order, head at cell 0
// ----------------------------------------------------------------------------
`default_nettype none

module ffa_chain (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       clear,
  input  wire logic [ffa_pkg::SIZE_W-1:0] init_size,
  input  wire logic                       pop,
  input  wire ffa_pkg::ent_t              push_ent,
  output ffa_pkg::ent_t                   head,
  output logic                            tail_free
);
  import ffa_pkg::*;

  ent_t ents [MAX_BLOCKS];

  for (genvar k = 0; k < MAX_BLOCKS; k++) begin : g_cell
    ent_t init_k;
    ent_t right_k;
    logic go_k;

    if (k == 0) begin : g_head
      assign init_k = '{vld: 1'b1, used: 1'b0, size: init_size};
      assign go_k   = pop;
    end else begin : g_body
      assign init_k = '0;
      assign go_k   = !ents[k-1].vld;
    end

    if (k == MAX_BLOCKS - 1) begin : g_tail
      assign right_k = push_ent;
    end else begin : g_mid
      assign right_k = ents[k+1];
    end

    ffa_cell u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .clear (clear),
      .init  (init_k),
      .go    (go_k),
      .right (right_k),
      .ent   (ents[k])
    );
  end

  assign head      = ents[0];
  assign tail_free = !ents[MAX_BLOCKS-1].vld;

endmodule

`default_nettype wire

>>> design/first_fit_heap_allocator_core.sv
// ----------------------------------------------------------------------------
// first_fit_heap_allocator_core
// first-fit heap allocator with block split and free-block merge
// ----------------------------------------------------------------------------
// requests arrive on the in_ channel (valid/ready), one result beat per request
// leaves on the out_ channel through an output register. heap_base and
// heap_bytes must be written over the apb port only while idle, which the
// block does not enforce; a write resets the table to one free block.
// the block table lives in a row of 256 queue cells. every request streams
// the whole table once from the head cell back into the tail cell: entries
// leave the head one at a time, and entries pushed at the tail ripple back
// towards the head cell by cell. a free that matches a block adds a second
// pass over the table that merges runs of free blocks. one request is in
// work at a time; the next is taken once the result sits in the output
// register, so a stalled receiver holds the block only when a second result
// is ready.
// after reset the table holds one free block of heap_bytes minus the header.
// ----------------------------------------------------------------------------
`default_nettype none

module first_fit_heap_allocator_core (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic        in_req_type,
  input  wire logic [24:0] in_req_size,
  input  wire logic [31:0] in_free_address,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [31:0]      out_alloc_address,
  output logic [1:0]       out_status,
  output logic [24:0]      out_free_bytes,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);
  import ffa_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_WALK,
    S_MERGE,
    S_RESP
  } state_t;

  state_t             state_r, state_nxt;
  logic [31:0]        base_r, base_nxt;
  logic [24:0]        bytes_r, bytes_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic [CNT_W-1:0]   todo_r, todo_nxt;
  logic [OFF_W-1:0]   off_r, off_nxt;
  logic [24:0]        sum_r, sum_nxt;
  logic               hit_r, hit_nxt;
  logic               type_r, type_nxt;
  logic [WANT_W-1:0]  want_r, want_nxt;
  logic               zero_r, zero_nxt;
  logic [31:0]        faddr_r, faddr_nxt;
  logic [31:0]        addr_r, addr_nxt;
  ent_t               ob_r, ob_nxt;
  ent_t               pend_r, pend_nxt;
  ent_t               acc_r, acc_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [31:0]        out_addr_r, out_addr_nxt;
  status_t            out_status_r, out_status_nxt;
  logic [24:0]        out_free_r, out_free_nxt;

  logic               cfg_wr;
  logic [24:0]        init_hb;
  ent_t               head;
  ent_t               push_ent;
  logic               tail_free;
  logic               pop;
  logic               push;
  logic               ob_free;
  logic               fit;
  logic               split;
  logic [31:0]        blk_addr;

  assign cfg_wr  = psel && penable && pwrite;
  assign pready  = 1'b1;
  assign prdata  = (paddr[2] == REG_BYTES) ? 32'(bytes_r) : base_r;
  assign init_hb = !rst_n ? 25'(RST_HEAP_BYTES) :
                   (cfg_wr && paddr[2] == REG_BYTES) ? pwdata[24:0] : bytes_r;

  ffa_chain u_chain (
    .clk       (clk),
    .rst_n     (rst_n),
    .clear     (cfg_wr),
    .init_size (first_size(init_hb)),
    .pop       (pop),
    .push_ent  (push_ent),
    .head      (head),
    .tail_free (tail_free)
  );

  assign push     = ob_r.vld && tail_free;
  assign push_ent = push ? ob_r : '0;
  assign ob_free  = !ob_r.vld || push;
  assign fit      = !head.used && ({2'b00, head.size} >= want_r);
  assign split    = ({2'b00, head.size} > want_r + WANT_W'(HEADER_BYTES)) &&
                    (cnt_r < CNT_W'(MAX_BLOCKS));
  assign blk_addr = base_r + 32'(off_r) + 32'(HEADER_BYTES);
  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    state_nxt      = state_r;
    base_nxt       = base_r;
    bytes_nxt      = bytes_r;
    cnt_nxt        = cnt_r;
    todo_nxt       = todo_r;
    off_nxt        = off_r;
    sum_nxt        = sum_r;
    hit_nxt        = hit_r;
    type_nxt       = type_r;
    want_nxt       = want_r;
    zero_nxt       = zero_r;
    faddr_nxt      = faddr_r;
    addr_nxt       = addr_r;
    ob_nxt         = ob_r;
    pend_nxt       = pend_r;
    acc_nxt        = acc_r;
    out_valid_nxt  = out_valid_r;
    out_addr_nxt   = out_addr_r;
    out_status_nxt = out_status_r;
    out_free_nxt   = out_free_r;
    pop            = 1'b0;

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (push) begin
      ob_nxt.vld = 1'b0;
      if (!ob_r.used) begin
        sum_nxt = sum_r + 25'(ob_r.size);
      end
    end

    if (cfg_wr) begin
      if (paddr[2] == REG_BYTES) begin
        bytes_nxt = pwdata[24:0];
      end else begin
        base_nxt = pwdata;
      end
      cnt_nxt = CNT_W'(1);
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          type_nxt  = in_req_type;
          want_nxt  = (WANT_W'(in_req_size) + WANT_W'(7)) & ~WANT_W'(7);
          zero_nxt  = (in_req_size == '0);
          faddr_nxt = in_free_address;
          hit_nxt   = 1'b0;
          off_nxt   = '0;
          sum_nxt   = '0;
          todo_nxt  = cnt_r;
          state_nxt = S_WALK;
        end
      end
      S_WALK: begin
        if (pend_r.vld) begin
          if (ob_free) begin
            ob_nxt       = pend_r;
            pend_nxt.vld = 1'b0;
          end
        end else if (todo_r != '0) begin
          if (head.vld && ob_free) begin
            pop      = 1'b1;
            todo_nxt = todo_r - CNT_W'(1);
            ob_nxt   = head;
            off_nxt  = off_r + OFF_W'(HEADER_BYTES) + OFF_W'(head.size);
            if (type_r == REQ_ALLOC) begin
              if (!hit_r && !zero_r && fit) begin
                hit_nxt     = 1'b1;
                addr_nxt    = blk_addr;
                ob_nxt.used = 1'b1;
                if (split) begin
                  ob_nxt.size = want_r[SIZE_W-1:0];
                  pend_nxt    = '{vld: 1'b1, used: 1'b0,
                                  size: head.size - want_r[SIZE_W-1:0] -
                                        SIZE_W'(HEADER_BYTES)};
                  cnt_nxt     = cnt_r + CNT_W'(1);
                end
              end
            end else begin
              if (!hit_r && faddr_r != '0 && blk_addr == faddr_r) begin
                hit_nxt     = 1'b1;
                ob_nxt.used = 1'b0;
              end
            end
          end
        end else if (!ob_r.vld) begin
          if (type_r == REQ_FREE && hit_r) begin
            todo_nxt    = cnt_r;
            sum_nxt     = '0;
            acc_nxt.vld = 1'b0;
            state_nxt   = S_MERGE;
          end else begin
            state_nxt = S_RESP;
          end
        end
      end
      S_MERGE: begin
        if (todo_r != '0) begin
          if (head.vld) begin
            if (!acc_r.vld) begin
              acc_nxt  = head;
              pop      = 1'b1;
              todo_nxt = todo_r - CNT_W'(1);
            end else if (!acc_r.used && !head.used) begin
              acc_nxt.size = acc_r.size + head.size + SIZE_W'(HEADER_BYTES);
              pop          = 1'b1;
              todo_nxt     = todo_r - CNT_W'(1);
              cnt_nxt      = cnt_r - CNT_W'(1);
            end else if (ob_free) begin
              ob_nxt   = acc_r;
              acc_nxt  = head;
              pop      = 1'b1;
              todo_nxt = todo_r - CNT_W'(1);
            end
          end
        end else if (acc_r.vld) begin
          if (ob_free) begin
            ob_nxt      = acc_r;
            acc_nxt.vld = 1'b0;
          end
        end else if (!ob_r.vld) begin
          state_nxt = S_RESP;
        end
      end
      S_RESP: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_free_nxt  = sum_r;
          if (type_r == REQ_ALLOC) begin
            out_addr_nxt   = hit_r ? addr_r : '0;
            out_status_nxt = hit_r ? ST_OK : ST_FAIL;
          end else begin
            out_addr_nxt   = '0;
            out_status_nxt = (faddr_r == '0 || hit_r) ? ST_OK : ST_UNKNOWN;
          end
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      base_r      <= '0;
      bytes_r     <= 25'(RST_HEAP_BYTES);
      cnt_r       <= CNT_W'(1);
      todo_r      <= '0;
      ob_r        <= '0;
      pend_r      <= '0;
      acc_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      base_r      <= base_nxt;
      bytes_r     <= bytes_nxt;
      cnt_r       <= cnt_nxt;
      todo_r      <= todo_nxt;
      ob_r        <= ob_nxt;
      pend_r      <= pend_nxt;
      acc_r       <= acc_nxt;
      out_valid_r <= out_valid_nxt;
    end
    off_r        <= off_nxt;
    sum_r        <= sum_nxt;
    hit_r        <= hit_nxt;
    type_r       <= type_nxt;
    want_r       <= want_nxt;
    zero_r       <= zero_nxt;
    faddr_r      <= faddr_nxt;
    addr_r       <= addr_nxt;
    out_addr_r   <= out_addr_nxt;
    out_status_r <= out_status_nxt;
    out_free_r   <= out_free_nxt;
  end

  assign out_valid         = out_valid_r;
  assign out_alloc_address = out_addr_r;
  assign out_status        = out_status_r;
  assign out_free_bytes    = out_free_r;

  // table never empties and never overflows
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r != '0 && cnt_r <= CNT_W'(MAX_BLOCKS))
    else $error("block count out of range");

  // no entry is left in flight between requests
  a_idle_empty: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_IDLE |-> !ob_r.vld && !pend_r.vld && !acc_r.vld)
    else $error("entry stranded in controller");

  // split remainder and merge accumulator belong to different passes
  a_pend_acc: assert property (@(posedge clk) disable iff (!rst_n)
    !(pend_r.vld && acc_r.vld))
    else $error("split and merge overlap");

  // a result beat carries a defined status code
  a_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> out_status_r == ST_OK || out_status_r == ST_FAIL ||
                    out_status_r == ST_UNKNOWN)
    else $error("bad status");

endmodule

`default_nettype wire

>>> tb/testbench.sv
// ----------------------------------------------------------------------------
// first-fit heap allocator testbench
// drives alloc and free requests with random gaps and output stalls, predicts
// each result from a private copy of the block table and checks every beat
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
  import ffa_pkg::*;

  typedef struct {
    logic        kind;
    logic [24:0] size;
    logic [31:0] addr;
  } req_t;

  typedef struct {
    logic [31:0] addr;
    status_t     st;
    logic [24:0] fbytes;
  } resp_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic in_req_type = 1'b0;
  logic [24:0] in_req_size = '0;
  logic [31:0] in_free_address = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [31:0] out_alloc_address;
  logic [1:0] out_status;
  logic [24:0] out_free_bytes;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [2:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  req_t pending_reqs[$];
  resp_t expected_resps[$];
  int errors = 0;
  bit idle_on = 1'b1;
  bit hold_send = 1'b0;
  bit in_fire = 1'b0;

  // predictor state
  logic [31:0] m_base;
  logic [24:0] m_bytes;
  logic [23:0] m_size[MAX_BLOCKS];
  bit m_used[MAX_BLOCKS];
  int m_count;
  logic [31:0] live_addrs[$];

  first_fit_heap_allocator_core i_dut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic void clear_heap();
    logic [24:0] tot;
    tot = (m_bytes > 25'(HEAP_LIMIT)) ? 25'(HEAP_LIMIT) : m_bytes;
    for (int i = 0; i < MAX_BLOCKS; i++) begin
      m_size[i] = '0;
      m_used[i] = 1'b0;
    end
    m_size[0] = (tot > 25'(HEADER_BYTES)) ? 24'(tot - 25'(HEADER_BYTES)) : '0;
    m_count = 1;
    live_addrs.delete();
  endfunction

  function automatic void merge_runs();
    int i;
    i = 0;
    while (i + 1 < m_count) begin
      if (!m_used[i] && !m_used[i+1]) begin
        m_size[i] = m_size[i] + m_size[i+1] + 24'(HEADER_BYTES);
        for (int j = i + 1; j + 1 < m_count; j++) begin
          m_size[j] = m_size[j+1];
          m_used[j] = m_used[j+1];
        end
        m_count--;
        m_size[m_count] = '0;
        m_used[m_count] = 1'b0;
      end else begin
        i++;
      end
    end
  endfunction

  function automatic resp_t heap_step(req_t r);
    resp_t res;
    logic [31:0] off;
    logic [31:0] want;
    logic [31:0] sum;
    res.addr = '0;
    res.st = ST_FAIL;
    off = '0;
    if (r.kind == REQ_FREE) begin
      res.st = ST_OK;
      if (r.addr != 0) begin
        res.st = ST_UNKNOWN;
        for (int i = 0; i < m_count; i++) begin
          if (m_base + off + HEADER_BYTES == r.addr) begin
            m_used[i] = 1'b0;
            merge_runs();
            res.st = ST_OK;
            break;
          end
          off += HEADER_BYTES + m_size[i];
        end
      end
    end else if (r.size != 0) begin
      want = (32'(r.size) + 7) & ~32'd7;
      for (int i = 0; i < m_count; i++) begin
        if (!m_used[i] && 32'(m_size[i]) >= want) begin
          if (32'(m_size[i]) > want + HEADER_BYTES && m_count < MAX_BLOCKS) begin
            for (int j = m_count; j > i + 1; j--) begin
              m_size[j] = m_size[j-1];
              m_used[j] = m_used[j-1];
            end
            m_size[i+1] = 24'(32'(m_size[i]) - want - HEADER_BYTES);
            m_used[i+1] = 1'b0;
            m_size[i] = 24'(want);
            m_count++;
          end
          m_used[i] = 1'b1;
          res.addr = m_base + off + HEADER_BYTES;
          res.st = ST_OK;
          break;
        end
        off += HEADER_BYTES + m_size[i];
      end
    end
    sum = '0;
    for (int i = 0; i < m_count; i++) begin
      if (!m_used[i]) sum += m_size[i];
    end
    res.fbytes = 25'(sum);
    return res;
  endfunction

  // driver
  always @(negedge clk) begin
    if (rst_n) begin
      if (!in_valid || in_fire) begin
        if (pending_reqs.size() > 0 && !hold_send &&
            !(idle_on && $urandom_range(99) < 34)) begin
          req_t r;
          r = pending_reqs.pop_front();
          in_valid <= 1'b1;
          in_req_type <= r.kind;
          in_req_size <= r.size;
          in_free_address <= r.addr;
        end else begin
          in_valid <= 1'b0;
        end
      end
      out_ready <= !(idle_on && $urandom_range(99) < 34);
    end
  end

  // sampled at the accepting edge
  always @(posedge clk) begin
    in_fire = rst_n && in_valid && in_ready;
    if (in_fire) begin
      req_t r;
      r.kind = in_req_type;
      r.size = in_req_size;
      r.addr = in_free_address;
      expected_resps.push_back(heap_step(r));
    end
  end

  // monitor
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (expected_resps.size() == 0) begin
        $display("%0t: result beat with nothing expected", $realtime);
        errors++;
      end else begin
        resp_t e;
        e = expected_resps.pop_front();
        if (out_alloc_address !== e.addr) begin
          $display("%0t: alloc_address exp %h got %h", $realtime, e.addr, out_alloc_address);
          errors++;
        end
        if (out_status !== e.st) begin
          $display("%0t: status exp %0d got %0d", $realtime, e.st, out_status);
          errors++;
        end
        if (out_free_bytes !== e.fbytes) begin
          $display("%0t: free_bytes exp %0d got %0d", $realtime, e.fbytes, out_free_bytes);
          errors++;
        end
      end
    end
  end

  task automatic wait_drain();
    while (pending_reqs.size() > 0 || in_valid || expected_resps.size() > 0)
      @(posedge clk);
    repeat (1200) @(posedge clk);
  endtask

  task automatic write_reg(input logic ridx, input logic [31:0] val);
    @(negedge clk);
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= 3'(ridx) << 2;
    pwdata <= val;
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (ridx == REG_BASE) m_base = val;
    else m_bytes = val[24:0];
    clear_heap();
  endtask

  task automatic push_alloc(input logic [24:0] sz);
    req_t r;
    r.kind = REQ_ALLOC;
    r.size = sz;
    r.addr = $urandom;
    pending_reqs.push_back(r);
  endtask

  task automatic push_free(input logic [31:0] a);
    req_t r;
    r.kind = REQ_FREE;
    r.size = 25'($urandom);
    r.addr = a;
    pending_reqs.push_back(r);
  endtask

  function automatic logic [31:0] live_guess();
    logic [31:0] off;
    int pick;
    off = '0;
    pick = $urandom_range(m_count > 0 ? m_count - 1 : 0);
    // guesses from the current predicted table; content moves as items run
    for (int i = 0; i < pick; i++) off += HEADER_BYTES + m_size[i];
    return m_base + off + HEADER_BYTES;
  endfunction

  // random phase; sizes kept small relative to the heap so the table fills
  task automatic random_phase(input int n, input int maxsz);
    logic [31:0] handles[$];
    int k;
    for (int i = 0; i < n; i++) begin
      k = $urandom_range(99);
      if (k < 50) begin
        push_alloc(25'($urandom_range(maxsz, 1)));
        handles.push_back(m_base + HEADER_BYTES + 32'($urandom_range(maxsz * 300)) * 8);
      end else if (k < 85) begin
        // free of a guessed block: predicted address of some block in the table
        push_free(live_guess());
      end else if (k < 90) begin
        push_free('0);
      end else if (k < 95) begin
        push_free($urandom);
      end else if (k < 97) begin
        push_alloc('0);
      end else begin
        push_alloc(25'($urandom));
      end
    end
  endtask

  task automatic wait_accept();
    while (pending_reqs.size() > 0 || in_valid) @(posedge clk);
  endtask

  // allocate n blocks of random size, waiting for each request to be accepted
  task automatic alloc_free_seq(input int n, input int maxsz);
    for (int i = 0; i < n; i++) begin
      push_alloc(25'($urandom_range(maxsz, 1)));
      wait_accept();
    end
  endtask

  task automatic free_live_random(input int n);
    logic [31:0] off;
    logic [31:0] used_addrs[$];
    for (int r = 0; r < n; r++) begin
      wait_accept();
      while (expected_resps.size() > 0) @(posedge clk);
      used_addrs.delete();
      off = '0;
      for (int i = 0; i < m_count; i++) begin
        if (m_used[i]) used_addrs.push_back(m_base + off + HEADER_BYTES);
        off += HEADER_BYTES + m_size[i];
      end
      if (used_addrs.size() > 0)
        push_free(used_addrs[$urandom_range(used_addrs.size() - 1)]);
      else
        push_alloc(25'($urandom_range(64, 1)));
      if ($urandom_range(3) == 0) push_alloc(25'($urandom_range(200, 1)));
    end
  endtask

  initial begin
    m_base = '0;
    m_bytes = 25'(RST_HEAP_BYTES);
    clear_heap();
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed
    push_alloc('0);
    push_alloc(25'd1);
    push_alloc(25'd8);
    push_alloc(25'd9);
    push_free('0);
    push_free(32'hffff_ffff);
    push_free(32'd12);
    push_free(32'd12);
    push_free(32'd28);
    push_alloc(25'h1ff_ffff);
    push_alloc(25'(RST_HEAP_BYTES - HEADER_BYTES));
    push_free(32'd12);
    push_alloc(25'(RST_HEAP_BYTES - HEADER_BYTES - 4));
    push_alloc(25'd1);
    wait_drain();

    // table full: many tiny allocs on default heap
    alloc_free_seq(0, 1);
    for (int i = 0; i < 260; i++) push_alloc(25'($urandom_range(16, 1)));
    free_live_random(60);
    wait_drain();

    // extremes of the config
    write_reg(REG_BASE, 32'hffff_fff0);
    write_reg(REG_BYTES, 25'h1ff_ffff);
    push_alloc(25'(HEAP_LIMIT));
    push_alloc(25'(HEAP_LIMIT - HEADER_BYTES));
    push_free(32'hffff_fffc);
    random_phase(40, 4096);
    wait_drain();

    write_reg(REG_BYTES, 25'd64);
    push_alloc(25'd52);
    push_alloc(25'd1);
    push_free(32'hffff_fffc);
    push_alloc(25'd16);
    push_alloc(25'd16);
    wait_drain();
    write_reg(REG_BYTES, 25'd4);
    push_alloc(25'd1);
    push_free(32'hffff_fffc);
    wait_drain();

    write_reg(REG_BASE, 32'h0000_1000);
    write_reg(REG_BYTES, 25'd8192);
    idle_on = 1'b0;
    random_phase(150, 120);
    free_live_random(60);
    wait_drain();
    idle_on = 1'b1;

    write_reg(REG_BASE, $urandom);
    write_reg(REG_BYTES, 25'd20000);
    random_phase(200, 200);
    free_live_random(120);
    hold_send = 1'b1;
    while (in_valid || expected_resps.size() > 0) @(posedge clk);
    hold_send = 1'b0;
    wait_drain();

    write_reg(REG_BASE, '0);
    write_reg(REG_BYTES, 25'(RST_HEAP_BYTES));
    random_phase(90, 3000);
    free_live_random(100);
    wait_drain();

    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  initial begin
    #2000ms;
    $display("FAILURE");
    $finish;
  end

endmodule

>>> first_fit_heap_allocator_core.f
design/ffa_pkg.sv
design/ffa_cell.sv
design/ffa_chain.sv
design/first_fit_heap_allocator_core.sv
tb/testbench.sv
